@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent assertions in the RTL checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside of reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/srtpkd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SRTP IV and key derivation package
// Widths, register indexes and the pipeline stage type shared by the block.
// ----------------------------------------------------------------------------
package srtpkd_pkg;

   localparam int HALF_BITS         = 64;
   localparam int INDEX_BITS        = 48;
   localparam int SALT_BITS         = 112;
   localparam int SALT_HIGH_BITS    = SALT_BITS - HALF_BITS;
   localparam int RATE_BITS         = 32;
   localparam int INDEX_LENGTH_BITS = 49;
   localparam int LABEL_BITS        = 8;
   localparam int SSRC_BITS         = 32;
   localparam int PROD_BITS         = LABEL_BITS + INDEX_LENGTH_BITS;
   localparam int WIDE_BITS         = 2 * HALF_BITS;
   localparam int IV_SALT_SHIFT     = WIDE_BITS - SALT_BITS;
   localparam int IV_INDEX_SHIFT    = 16;
   localparam int IV_SSRC_SHIFT     = HALF_BITS;
   localparam int CSR_ADDR_BITS     = 6;
   localparam int CSR_DATA_BITS     = 64;
   localparam int CSR_SEL_LSB       = 3;

   localparam logic [INDEX_LENGTH_BITS-1:0] INDEX_LENGTH_RESET =
      {1'b1, {(INDEX_LENGTH_BITS-1){1'b0}}};

   typedef enum logic [CSR_ADDR_BITS-CSR_SEL_LSB-1:0] {
      REG_SESSION_SALT_HIGH = 3'd0,
      REG_SESSION_SALT_LOW  = 3'd1,
      REG_MASTER_SALT_HIGH  = 3'd2,
      REG_MASTER_SALT_LOW   = 3'd3,
      REG_KD_RATE           = 3'd4,
      REG_INDEX_LENGTH      = 3'd5
   } csr_index_type;

   typedef enum logic {
      ACTION_IV = 1'b0,
      ACTION_KD = 1'b1
   } action_type;

   typedef struct packed {
      logic                  action;
      logic [HALF_BITS-1:0]  side_high;
      logic [HALF_BITS-1:0]  side_low;
      logic [RATE_BITS-1:0]  rem;
      logic [INDEX_BITS-1:0] dq;
   } stage_type;

endpackage

@@ hw/rtl/srtpkd_div_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Divider cell
// One restoring division step: takes the next dividend bit, yields one
// quotient bit and registers the item for the next cell.
// ----------------------------------------------------------------------------
module srtpkd_div_cell (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  logic [srtpkd_pkg::RATE_BITS-1:0]    divisor,
   input  logic                                in_valid,
   input  srtpkd_pkg::stage_type               in_stage,
   output logic                                out_valid,
   output srtpkd_pkg::stage_type               out_stage
);
   import srtpkd_pkg::*;

   logic                 valid_ff;
   stage_type            stage_ff;
   stage_type            stage_in;
   logic [RATE_BITS:0]   partial;
   logic [RATE_BITS:0]   diff;
   logic                 take;

   always_comb begin
      partial = {in_stage.rem, in_stage.dq[INDEX_BITS-1]};
      diff    = partial - {1'b0, divisor};
      take    = (partial >= {1'b0, divisor});
      stage_in = in_stage;
      stage_in.rem = take ? diff[RATE_BITS-1:0] : partial[RATE_BITS-1:0];
      stage_in.dq  = {in_stage.dq[INDEX_BITS-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule

@@ hw/rtl/srtp_iv_and_key_derivation_input_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SRTP IV and key derivation input
// Forms the AES counter-mode packet IV or the key derivation input x.
// ----------------------------------------------------------------------------
// Each request item on the req_ channel asks for one 128-bit value: action 0
// gives the packet IV from the session salt, SSRC and packet index; action 1
// gives x from the master salt, label, index length and the packet index
// divided by the key derivation rate. The answer leaves on the rsp_ channel
// as two 64-bit halves, one item per request, in request order.
// The block is a pipeline: an input stage that forms the IV and the label
// product, a chain of 48 divider cells that each produce one quotient bit,
// and an output register. One item can enter in every cycle that the chain
// is not frozen, so throughput is one item per cycle when nothing stalls.
// When rsp_stall holds a waiting result, the whole chain freezes and
// req_stall is raised in the same cycle; bubbles do not collapse.
// Reset clears all valid flags and sets the configuration registers to their reset values.
// The csr_ port is to be written by the user only while no item is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module srtp_iv_and_key_derivation_input_top (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_valid,
   output logic                                        req_stall,
   input  logic                                        req_action,
   input  logic [srtpkd_pkg::SSRC_BITS-1:0]            req_ssrc,
   input  logic [srtpkd_pkg::INDEX_BITS-1:0]           req_packet_index,
   input  logic [srtpkd_pkg::LABEL_BITS-1:0]           req_label,
   output logic                                        rsp_valid,
   input  logic                                        rsp_stall,
   output logic [srtpkd_pkg::HALF_BITS-1:0]            rsp_result_high,
   output logic [srtpkd_pkg::HALF_BITS-1:0]            rsp_result_low,
   input  logic                                        csr_psel,
   input  logic                                        csr_penable,
   input  logic                                        csr_pwrite,
   input  logic [srtpkd_pkg::CSR_ADDR_BITS-1:0]        csr_paddr,
   input  logic [srtpkd_pkg::CSR_DATA_BITS-1:0]        csr_pwdata,
   output logic [srtpkd_pkg::CSR_DATA_BITS-1:0]        csr_prdata,
   output logic                                        csr_pready
);
   import srtpkd_pkg::*;

   logic [SALT_HIGH_BITS-1:0]    session_salt_high_ff;
   logic [HALF_BITS-1:0]         session_salt_low_ff;
   logic [SALT_HIGH_BITS-1:0]    master_salt_high_ff;
   logic [HALF_BITS-1:0]         master_salt_low_ff;
   logic [RATE_BITS-1:0]         kd_rate_ff;
   logic [INDEX_LENGTH_BITS-1:0] index_length_ff;

   csr_index_type                csr_sel;
   logic                         csr_write;

   logic                         advance;
   logic                         front_valid_ff;
   stage_type                    front_ff;
   stage_type                    front_in;
   logic [WIDE_BITS-1:0]         iv_wide;
   logic [PROD_BITS-1:0]         product;

   logic                         chain_valid [0:INDEX_BITS];
   stage_type                    chain_stage [0:INDEX_BITS];

   stage_type                    last_stage;
   logic [INDEX_BITS-1:0]        ratio;
   logic [HALF_BITS:0]           key_sum;
   logic [HALF_BITS-1:0]         result_high_in;
   logic [HALF_BITS-1:0]         result_low_in;
   logic                         rsp_valid_ff;
   logic [HALF_BITS-1:0]         result_high_ff;
   logic [HALF_BITS-1:0]         result_low_ff;

   // Configuration registers.
   assign csr_sel    = csr_index_type'(csr_paddr[CSR_ADDR_BITS-1:CSR_SEL_LSB]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         session_salt_high_ff <= '0;
         session_salt_low_ff  <= '0;
         master_salt_high_ff  <= '0;
         master_salt_low_ff   <= '0;
         kd_rate_ff           <= '0;
         index_length_ff      <= INDEX_LENGTH_RESET;
      end else if (csr_write) begin
         case (csr_sel)
            REG_SESSION_SALT_HIGH: session_salt_high_ff <= csr_pwdata[SALT_HIGH_BITS-1:0];
            REG_SESSION_SALT_LOW:  session_salt_low_ff  <= csr_pwdata[HALF_BITS-1:0];
            REG_MASTER_SALT_HIGH:  master_salt_high_ff  <= csr_pwdata[SALT_HIGH_BITS-1:0];
            REG_MASTER_SALT_LOW:   master_salt_low_ff   <= csr_pwdata[HALF_BITS-1:0];
            REG_KD_RATE:           kd_rate_ff           <= csr_pwdata[RATE_BITS-1:0];
            REG_INDEX_LENGTH:      index_length_ff      <= csr_pwdata[INDEX_LENGTH_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_sel)
         REG_SESSION_SALT_HIGH: csr_prdata = CSR_DATA_BITS'(session_salt_high_ff);
         REG_SESSION_SALT_LOW:  csr_prdata = CSR_DATA_BITS'(session_salt_low_ff);
         REG_MASTER_SALT_HIGH:  csr_prdata = CSR_DATA_BITS'(master_salt_high_ff);
         REG_MASTER_SALT_LOW:   csr_prdata = CSR_DATA_BITS'(master_salt_low_ff);
         REG_KD_RATE:           csr_prdata = CSR_DATA_BITS'(kd_rate_ff);
         REG_INDEX_LENGTH:      csr_prdata = CSR_DATA_BITS'(index_length_ff);
         default:               csr_prdata = '0;
      endcase
   end

   // The chain moves as one unless a finished result is held by the receiver.
   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   // Input stage: the IV for action 0, the label product for action 1.
   always_comb begin
      iv_wide = (WIDE_BITS'({session_salt_high_ff, session_salt_low_ff}) << IV_SALT_SHIFT)
              ^ (WIDE_BITS'(req_ssrc) << IV_SSRC_SHIFT)
              ^ (WIDE_BITS'(req_packet_index) << IV_INDEX_SHIFT);
      product = PROD_BITS'(req_label) * PROD_BITS'(index_length_ff);
      front_in.action = req_action;
      front_in.rem    = '0;
      front_in.dq     = req_packet_index;
      if (req_action == ACTION_IV) begin
         front_in.side_high = iv_wide[WIDE_BITS-1:HALF_BITS];
         front_in.side_low  = iv_wide[HALF_BITS-1:0];
      end else begin
         front_in.side_high = '0;
         front_in.side_low  = HALF_BITS'(product);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else if (advance) begin
         front_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         front_ff <= front_in;
      end
   end

   assign chain_valid[0] = front_valid_ff;
   assign chain_stage[0] = front_ff;

   // Divider chain: one quotient bit per cell, most significant first.
   for (genvar i = 0; i < INDEX_BITS; i++) begin : g_cell
      srtpkd_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .divisor   (kd_rate_ff),
         .in_valid  (chain_valid[i]),
         .in_stage  (chain_stage[i]),
         .out_valid (chain_valid[i+1]),
         .out_stage (chain_stage[i+1])
      );
   end

   // Output stage: key identifier and final result.
   always_comb begin
      last_stage = chain_stage[INDEX_BITS];
      ratio      = (kd_rate_ff == '0) ? '0 : last_stage.dq;
      key_sum    = {1'b0, last_stage.side_low} + (HALF_BITS + 1)'(ratio);
      if (last_stage.action == ACTION_IV) begin
         result_high_in = last_stage.side_high;
         result_low_in  = last_stage.side_low;
      end else begin
         result_high_in = HALF_BITS'(master_salt_high_ff
                                     ^ SALT_HIGH_BITS'(key_sum[HALF_BITS]));
         result_low_in  = master_salt_low_ff ^ key_sum[HALF_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= chain_valid[INDEX_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_high_ff <= result_high_in;
         result_low_ff  <= result_low_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_high = result_high_ff;
   assign rsp_result_low  = result_low_ff;

endmodule

@@ hw/rtl/srtpkd_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SRTP IV and key derivation checker
// Port-level assertions on the top level, attached by a bind statement.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module srtpkd_checker (
   input logic                                        clock,
   input logic                                        reset,
   input logic                                        req_valid,
   input logic                                        req_stall,
   input logic                                        req_action,
   input logic [srtpkd_pkg::SSRC_BITS-1:0]            req_ssrc,
   input logic [srtpkd_pkg::INDEX_BITS-1:0]           req_packet_index,
   input logic [srtpkd_pkg::LABEL_BITS-1:0]           req_label,
   input logic                                        rsp_valid,
   input logic                                        rsp_stall,
   input logic [srtpkd_pkg::HALF_BITS-1:0]            rsp_result_high,
   input logic [srtpkd_pkg::HALF_BITS-1:0]            rsp_result_low,
   input logic                                        csr_psel,
   input logic                                        csr_penable,
   input logic                                        csr_pwrite,
   input logic [srtpkd_pkg::CSR_ADDR_BITS-1:0]        csr_paddr,
   input logic [srtpkd_pkg::CSR_DATA_BITS-1:0]        csr_pwdata,
   input logic [srtpkd_pkg::CSR_DATA_BITS-1:0]        csr_prdata,
   input logic                                        csr_pready
);
   import srtpkd_pkg::*;

   // A held result stays offered.
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid, "rsp item dropped while stalled")

   // A held result keeps its value.
   `ASSERT_CLK(a_rsp_stable, clock, reset, rsp_valid && rsp_stall |=> $stable(rsp_result_high) && $stable(rsp_result_low), "rsp item changed while stalled")

   // The input backs up only behind a held result.
   `ASSERT_CLK(a_req_backpressure, clock, reset, req_stall |-> rsp_valid && rsp_stall, "req stalled without a held result")

   // Nothing leaves in the cycle after reset.
   `ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "rsp item right after reset")

endmodule

bind srtp_iv_and_key_derivation_input_top srtpkd_checker u_srtpkd_checker (.*);

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SRTP IV and key derivation input testbench
// Sends packet IV and key derivation requests with directed extremes and random
// traffic under several register settings. Each result item is checked in order
// against values predicted here from the register writes. Both channels idle at
// random, and one long output hold-off fills the pipeline.
// ----------------------------------------------------------------------------
module tb_top;
   import srtpkd_pkg::*;

   localparam int CYCLE_LIMIT     = 400000;
   localparam int PIPE_LATENCY    = 50;
   localparam int HOLD_OFF_CYCLES = 160;
   localparam int PHASE_COUNT     = 8;
   localparam int PHASE_ITEMS     = 45;
   localparam int PRESSURE_ITEMS  = 80;
   localparam int REG_SEL_BITS    = CSR_ADDR_BITS - CSR_SEL_LSB;

   localparam logic [REG_SEL_BITS-1:0] UNMAPPED_INDEX_LOW  = 3'd6;
   localparam logic [REG_SEL_BITS-1:0] UNMAPPED_INDEX_HIGH = 3'd7;
   localparam logic [INDEX_BITS-1:0]   INDEX_MAX           = '1;

   typedef enum int {
      SETTING_ZERO,
      SETTING_ONES,
      SETTING_RANDOM
   } setting_type;

   logic                      clock            = 1'b0;
   logic                      reset            = 1'b1;
   logic                      req_valid        = 1'b0;
   logic                      req_stall;
   logic                      req_action       = 1'b0;
   logic [SSRC_BITS-1:0]      req_ssrc         = '0;
   logic [INDEX_BITS-1:0]     req_packet_index = '0;
   logic [LABEL_BITS-1:0]     req_label        = '0;
   logic                      rsp_valid;
   logic                      rsp_stall        = 1'b0;
   logic [HALF_BITS-1:0]      rsp_result_high;
   logic [HALF_BITS-1:0]      rsp_result_low;
   logic                      csr_psel         = 1'b0;
   logic                      csr_penable      = 1'b0;
   logic                      csr_pwrite       = 1'b0;
   logic [CSR_ADDR_BITS-1:0]  csr_paddr        = '0;
   logic [CSR_DATA_BITS-1:0]  csr_pwdata       = '0;
   logic [CSR_DATA_BITS-1:0]  csr_prdata;
   logic                      csr_pready;

   logic [SALT_HIGH_BITS-1:0]    session_salt_high = '0;
   logic [HALF_BITS-1:0]         session_salt_low  = '0;
   logic [SALT_HIGH_BITS-1:0]    master_salt_high  = '0;
   logic [HALF_BITS-1:0]         master_salt_low   = '0;
   logic [RATE_BITS-1:0]         kd_rate           = '0;
   logic [INDEX_LENGTH_BITS-1:0] index_length      = INDEX_LENGTH_RESET;

   logic [WIDE_BITS-1:0] pending_counter_blocks[$];

   int error_count     = 0;
   int cycle_count     = 0;
   bit gap_enable      = 1'b0;
   bit stall_enable    = 1'b0;
   int hold_off_asked  = 0;
   int hold_off_served = 0;
   int hold_off_left   = 0;
   int stall_run_left  = 0;

   srtp_iv_and_key_derivation_input_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_ssrc         (req_ssrc),
      .req_packet_index (req_packet_index),
      .req_label        (req_label),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_high  (rsp_result_high),
      .rsp_result_low   (rsp_result_low),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // The output side stalls in short or long runs; a hold-off request blocks it
   // for a long stretch.
   always @(posedge clock) begin
      if (hold_off_served != hold_off_asked) begin
         hold_off_served <= hold_off_asked;
         hold_off_left   <= HOLD_OFF_CYCLES - 1;
         rsp_stall       <= 1'b1;
      end else if (hold_off_left > 0) begin
         hold_off_left <= hold_off_left - 1;
         rsp_stall     <= 1'b1;
      end else if (stall_run_left > 0) begin
         stall_run_left <= stall_run_left - 1;
         rsp_stall      <= 1'b1;
      end else if (stall_enable && $urandom_range(0, 99) < 20) begin
         stall_run_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(0, 2);
         rsp_stall      <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   function automatic logic [WIDE_BITS-1:0] predict_counter_block(
      input action_type            act,
      input logic [SSRC_BITS-1:0]  ssrc,
      input logic [INDEX_BITS-1:0] pkt_index,
      input logic [LABEL_BITS-1:0] label
   );
      logic [WIDE_BITS-1:0]  counter_block;
      logic [WIDE_BITS-1:0]  key_id;
      logic [INDEX_BITS-1:0] quotient;
      if (act == ACTION_IV) begin
         counter_block = WIDE_BITS'({session_salt_high, session_salt_low}) << IV_SALT_SHIFT;
         counter_block ^= WIDE_BITS'(ssrc) << IV_SSRC_SHIFT;
         counter_block ^= WIDE_BITS'(pkt_index) << IV_INDEX_SHIFT;
      end else begin
         quotient = (kd_rate == '0) ? '0 : pkt_index / kd_rate;
         key_id = WIDE_BITS'(label) * WIDE_BITS'(index_length) + WIDE_BITS'(quotient);
         counter_block = WIDE_BITS'({master_salt_high, master_salt_low}) ^ key_id;
         counter_block[WIDE_BITS-1:SALT_BITS] = '0;
      end
      return counter_block;
   endfunction

   // A result item is taken at the next rising edge when it is valid and not
   // stalled at the falling edge.
   always @(negedge clock) begin : check_results
      logic [WIDE_BITS-1:0] expected;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_counter_blocks.size() == 0) begin
            $display("%0t: unexpected result item, got %h %h", $time,
                     rsp_result_high, rsp_result_low);
            error_count++;
         end else begin
            expected = pending_counter_blocks.pop_front();
            if (rsp_result_high !== expected[WIDE_BITS-1:HALF_BITS]) begin
               $display("%0t: result_high mismatch, expected %h, got %h", $time,
                        expected[WIDE_BITS-1:HALF_BITS], rsp_result_high);
               error_count++;
            end
            if (rsp_result_low !== expected[HALF_BITS-1:0]) begin
               $display("%0t: result_low mismatch, expected %h, got %h", $time,
                        expected[HALF_BITS-1:0], rsp_result_low);
               error_count++;
            end
         end
      end
   end

   function automatic logic [HALF_BITS-1:0] random_word();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [INDEX_BITS-1:0] random_packet_index();
      case ($urandom_range(0, 5))
         0: return INDEX_BITS'($urandom_range(0, 1000));
         1: return INDEX_MAX;
         2: return INDEX_MAX - INDEX_BITS'($urandom_range(0, 1000));
         default: return INDEX_BITS'(random_word());
      endcase
   endfunction

   task automatic write_register(input logic [REG_SEL_BITS-1:0] sel,
                                 input logic [CSR_DATA_BITS-1:0] value);
      bit done;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {sel, {CSR_SEL_LSB{1'b0}}};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      done = 1'b0;
      while (!done) begin
         @(negedge clock);
         done = csr_pready;
         @(posedge clock);
      end
      case (csr_index_type'(sel))
         REG_SESSION_SALT_HIGH: session_salt_high = value[SALT_HIGH_BITS-1:0];
         REG_SESSION_SALT_LOW:  session_salt_low  = value[HALF_BITS-1:0];
         REG_MASTER_SALT_HIGH:  master_salt_high  = value[SALT_HIGH_BITS-1:0];
         REG_MASTER_SALT_LOW:   master_salt_low   = value[HALF_BITS-1:0];
         REG_KD_RATE:           kd_rate           = value[RATE_BITS-1:0];
         REG_INDEX_LENGTH:      index_length      = value[INDEX_LENGTH_BITS-1:0];
         default: ;
      endcase
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_request(input action_type            act,
                               input logic [SSRC_BITS-1:0]  ssrc,
                               input logic [INDEX_BITS-1:0] pkt_index,
                               input logic [LABEL_BITS-1:0] label);
      int gap;
      int roll;
      bit taken;
      gap = 0;
      if (gap_enable) begin
         roll = $urandom_range(0, 99);
         if (roll < 60) gap = 0;
         else if (roll < 90) gap = $urandom_range(1, 3);
         else if (roll < 97) gap = $urandom_range(4, 10);
         else gap = $urandom_range(20, 60);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_action       <= act;
      req_ssrc         <= ssrc;
      req_packet_index <= pkt_index;
      req_label        <= label;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end
      pending_counter_blocks.push_back(predict_counter_block(act, ssrc, pkt_index, label));
   endtask

   task automatic send_random_request();
      send_request(action_type'($urandom_range(0, 1)), $urandom, random_packet_index(),
                   LABEL_BITS'($urandom));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_counter_blocks.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic configure_block(input setting_type setting);
      logic [RATE_BITS-1:0]         rate;
      logic [INDEX_LENGTH_BITS-1:0] length;
      if (setting == SETTING_ZERO) begin
         write_register(REG_SESSION_SALT_HIGH, '0);
         write_register(REG_SESSION_SALT_LOW, '0);
         write_register(REG_MASTER_SALT_HIGH, '0);
         write_register(REG_MASTER_SALT_LOW, '0);
         write_register(REG_KD_RATE, '0);
         write_register(REG_INDEX_LENGTH, '0);
      end else if (setting == SETTING_ONES) begin
         write_register(REG_SESSION_SALT_HIGH, '1);
         write_register(REG_SESSION_SALT_LOW, '1);
         write_register(REG_MASTER_SALT_HIGH, '1);
         write_register(REG_MASTER_SALT_LOW, '1);
         write_register(REG_KD_RATE, '1);
         write_register(REG_INDEX_LENGTH, '1);
      end else begin
         case ($urandom_range(0, 5))
            0: rate = '0;
            1: rate = 1;
            2: rate = $urandom_range(2, 64);
            3: rate = RATE_BITS'(1) << $urandom_range(0, RATE_BITS - 1);
            4: rate = '1;
            default: rate = $urandom;
         endcase
         case ($urandom_range(0, 4))
            0: length = '0;
            1: length = INDEX_LENGTH_RESET;
            2: length = '1;
            3: length = $urandom_range(1, 4096);
            default: length = INDEX_LENGTH_BITS'(random_word());
         endcase
         write_register(REG_SESSION_SALT_HIGH, random_word());
         write_register(REG_SESSION_SALT_LOW, random_word());
         write_register(REG_MASTER_SALT_HIGH, random_word());
         write_register(REG_MASTER_SALT_LOW, random_word());
         write_register(REG_KD_RATE, {$urandom, rate});
         write_register(REG_INDEX_LENGTH, {15'($urandom), length});
      end
   endtask

   task automatic test_reset_defaults();
      gap_enable   = 1'b0;
      stall_enable = 1'b0;
      send_request(ACTION_KD, $urandom, '0, 8'd1);
      send_request(ACTION_KD, $urandom, INDEX_MAX, 8'd255);
      send_request(ACTION_IV, '1, INDEX_MAX, LABEL_BITS'($urandom));
      send_request(ACTION_IV, '0, '0, LABEL_BITS'($urandom));
      wait_drained();
   endtask

   // Key identifiers never reach past the salt width with these field widths,
   // so the upper result bits are checked to stay clear.
   task automatic test_field_extremes();
      gap_enable   = 1'b0;
      stall_enable = 1'b0;
      configure_block(SETTING_ONES);
      send_request(ACTION_IV, '1, INDEX_MAX, LABEL_BITS'($urandom));
      send_request(ACTION_IV, 32'hAAAA_AAAA, 48'h5555_5555_5555, LABEL_BITS'($urandom));
      send_request(ACTION_KD, $urandom, INDEX_MAX, 8'd255);
      send_request(ACTION_KD, $urandom, INDEX_MAX, 8'd0);
      wait_drained();
      write_register(REG_SESSION_SALT_HIGH, 64'h5555_AAAA_AAAA_AAAA);
      write_register(REG_SESSION_SALT_LOW, 64'h5555_5555_5555_5555);
      write_register(REG_MASTER_SALT_HIGH, 64'hAAAA_5555_5555_5555);
      write_register(REG_MASTER_SALT_LOW, 64'hAAAA_AAAA_AAAA_AAAA);
      write_register(REG_KD_RATE, 64'hFFFF_FFFF_0000_0001);
      write_register(REG_INDEX_LENGTH, '0);
      send_request(ACTION_KD, $urandom, INDEX_MAX, 8'd255);
      send_request(ACTION_IV, '0, '0, LABEL_BITS'($urandom));
      send_request(ACTION_IV, 32'h5555_5555, 48'hAAAA_AAAA_AAAA, LABEL_BITS'($urandom));
      wait_drained();
      write_register(REG_KD_RATE, '0);
      write_register(REG_INDEX_LENGTH, INDEX_LENGTH_RESET);
      write_register(UNMAPPED_INDEX_LOW, '1);
      write_register(UNMAPPED_INDEX_HIGH, random_word());
      send_request(ACTION_KD, $urandom, INDEX_BITS'(random_word()), 8'd128);
      send_request(ACTION_KD, $urandom, INDEX_MAX, 8'd255);
      send_request(ACTION_IV, $urandom, INDEX_BITS'(random_word()), LABEL_BITS'($urandom));
      wait_drained();
   endtask

   task automatic test_random_settings();
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         if (phase == 0) configure_block(SETTING_ZERO);
         else if (phase == 1) configure_block(SETTING_ONES);
         else configure_block(SETTING_RANDOM);
         gap_enable   = (phase != 3) && (phase != 5);
         stall_enable = (phase != 3) && (phase != 4);
         repeat (PHASE_ITEMS) send_random_request();
         wait_drained();
      end
   endtask

   task automatic test_back_pressure();
      gap_enable   = 1'b0;
      stall_enable = 1'b0;
      configure_block(SETTING_RANDOM);
      hold_off_asked++;
      repeat (PRESSURE_ITEMS) send_random_request();
      wait_drained();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_field_extremes();
      test_random_settings();
      test_back_pressure();
      repeat (PIPE_LATENCY + 10) @(posedge clock);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/srtpkd_pkg.sv
hw/rtl/srtpkd_div_cell.sv
hw/rtl/srtp_iv_and_key_derivation_input_top.sv
hw/rtl/srtpkd_checker.sv
sim/tb_top.sv
